// ----- hw/rtl/assert_macros.svh -----
// Assertion helper macros for the slot pool RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define OSP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("slot pool check failed");

// Check that a condition never holds outside reset.
`define OSP_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("slot pool forbidden condition seen");

`endif

// ----- hw/rtl/osp_pkg.sv -----
// Shared types and constants for the ordered slot pool manager.
// No dependencies.
package osp_pkg;

   localparam int SLOT_W     = 5;
   localparam int MAX_RES    = 32;
   localparam int WALK_CNT_W = $clog2(MAX_RES);

   typedef enum logic [1:0] {
      CMD_CREATE      = 2'd0,
      CMD_RELEASE     = 2'd1,
      CMD_RELEASE_ALL = 2'd2,
      CMD_WALK        = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_POOL_FULL  = 2'd1,
      STAT_NOT_ACTIVE = 2'd2,
      STAT_EMPTY      = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [SLOT_W-1:0]   slot;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot_out;
      logic                last;
   } rsp_type;

endpackage

// ----- hw/rtl/ordered_slot_pool_manager_unit.sv -----
// Ordered slot pool manager: a LIFO free list and an insertion-ordered active list
// sharing one link memory. Depends on osp_pkg and assert_macros.svh.
//
// After reset the link memory is initialized by a sweep over every entry, during
// which req_ready stays low. Commands are handled one at a time. The link memory has
// one registered read port, so list traversal advances one link per cycle (a walk
// also holds while the output register is full). Create passes through ST_CREATE and
// ST_RESP, release of an inactive slot goes straight to ST_RESP, release of an active
// slot through ST_REL_WALK, ST_REL_FIN and ST_RESP, release-all through ST_RALL and
// ST_RESP, and walk sends one response per listed slot (up to 32). A finished result
// sits in an output register while the next command is taken.
module ordered_slot_pool_manager_unit
   import osp_pkg::*;
#(
   parameter int NUM_SLOTS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

`include "assert_macros.svh"

   localparam int IW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);

   typedef enum logic [7:0] {
      ST_INIT     = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_CREATE   = 8'b0000_0100,
      ST_REL_WALK = 8'b0000_1000,
      ST_REL_FIN  = 8'b0001_0000,
      ST_RALL     = 8'b0010_0000,
      ST_WALK     = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   logic [IW-1:0]           init_idx_ff, init_idx_in;
   logic [LW-1:0]           free_head_ff, free_head_in;
   logic [LW-1:0]           head_ff, head_in;
   logic [LW-1:0]           tail_ff, tail_in;
   logic [NUM_SLOTS-1:0]    active_ff, active_in;
   logic [LW-1:0]           cur_ff, cur_in;
   logic [LW-1:0]           prev_ff, prev_in;
   logic [IW-1:0]           rel_idx_ff, rel_idx_in;
   logic [WALK_CNT_W-1:0]   k_ff, k_in;
   status_type              resp_status_ff, resp_status_in;
   logic [SLOT_W-1:0]       resp_slot_ff, resp_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_item_ff, rsp_item_in;

   logic [LW-1:0]           link_mem [NUM_SLOTS];
   logic [LW-1:0]           link_rd_ff;
   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic [LW-1:0]           wr_data;
   logic [IW-1:0]           rd_addr;

   logic                    out_free;
   logic                    req_fire;
   logic                    req_in_range;
   logic [IW-1:0]           req_idx;
   logic                    walk_last;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign req_in_range = (32'(req_item.slot) < NUM_SLOTS);
   assign req_idx      = IW'(req_item.slot);
   assign walk_last    = (link_rd_ff >= NULL_LINK) || (k_ff == WALK_CNT_W'(MAX_RES - 1));
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_item     = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      init_idx_in    = init_idx_ff;
      free_head_in   = free_head_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      active_in      = active_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      rel_idx_in     = rel_idx_ff;
      k_in           = k_ff;
      resp_status_in = resp_status_ff;
      resp_slot_in   = resp_slot_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_item_in    = rsp_item_ff;
      wr_en          = 1'b0;
      wr_addr        = cur_ff[IW-1:0];
      wr_data        = NULL_LINK;
      rd_addr        = cur_ff[IW-1:0];

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_idx_ff;
            wr_data = LW'(init_idx_ff) + LW'(1);
            init_idx_in = init_idx_ff + IW'(1);
            if (init_idx_ff == IW'(NUM_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = (req_item.cmd == CMD_CREATE) ? free_head_ff[IW-1:0] : head_ff[IW-1:0];
            if (req_fire) begin
               resp_slot_in = '0;
               cur_in       = head_ff;
               prev_in      = NULL_LINK;
               k_in         = '0;
               rel_idx_in   = req_idx;
               unique case (req_item.cmd)
                  CMD_CREATE: begin
                     if (free_head_ff >= NULL_LINK) begin
                        resp_status_in = STAT_POOL_FULL;
                        state_in       = ST_RESP;
                     end else begin
                        // append to active tail now; free head advances next cycle
                        if (tail_ff >= NULL_LINK) begin
                           head_in = free_head_ff;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = tail_ff[IW-1:0];
                           wr_data = free_head_ff;
                        end
                        tail_in = free_head_ff;
                        active_in[free_head_ff[IW-1:0]] = 1'b1;
                        cur_in   = free_head_ff;
                        state_in = ST_CREATE;
                     end
                  end
                  CMD_RELEASE: begin
                     if (!req_in_range || !active_ff[req_idx]) begin
                        resp_status_in = STAT_NOT_ACTIVE;
                        resp_slot_in   = req_item.slot;
                        state_in       = ST_RESP;
                     end else begin
                        state_in = ST_REL_WALK;
                     end
                  end
                  CMD_RELEASE_ALL: begin
                     if (head_ff >= NULL_LINK) begin
                        resp_status_in = STAT_EMPTY;
                        state_in       = ST_RESP;
                     end else begin
                        state_in = ST_RALL;
                     end
                  end
                  CMD_WALK: begin
                     if (head_ff >= NULL_LINK) begin
                        resp_status_in = STAT_EMPTY;
                        state_in       = ST_RESP;
                     end else begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_CREATE: begin
            free_head_in   = link_rd_ff;
            wr_en          = 1'b1;
            wr_addr        = cur_ff[IW-1:0];
            wr_data        = NULL_LINK;
            resp_status_in = STAT_OK;
            resp_slot_in   = SLOT_W'(cur_ff);
            state_in       = ST_RESP;
         end
         ST_REL_WALK: begin
            if (cur_ff[IW-1:0] == rel_idx_ff) begin
               if (prev_ff >= NULL_LINK) begin
                  head_in = link_rd_ff;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = prev_ff[IW-1:0];
                  wr_data = link_rd_ff;
               end
               if (tail_ff == cur_ff) begin
                  tail_in = prev_ff;
               end
               active_in[rel_idx_ff] = 1'b0;
               state_in = ST_REL_FIN;
            end else begin
               prev_in = cur_ff;
               cur_in  = link_rd_ff;
               rd_addr = link_rd_ff[IW-1:0];
            end
         end
         ST_REL_FIN: begin
            wr_en          = 1'b1;
            wr_addr        = rel_idx_ff;
            wr_data        = free_head_ff;
            free_head_in   = LW'(rel_idx_ff);
            resp_status_in = STAT_OK;
            resp_slot_in   = SLOT_W'(rel_idx_ff);
            state_in       = ST_RESP;
         end
         ST_RALL: begin
            wr_en        = 1'b1;
            wr_addr      = cur_ff[IW-1:0];
            wr_data      = free_head_ff;
            free_head_in = cur_ff;
            active_in[cur_ff[IW-1:0]] = 1'b0;
            cur_in  = link_rd_ff;
            rd_addr = link_rd_ff[IW-1:0];
            if (link_rd_ff >= NULL_LINK) begin
               head_in        = NULL_LINK;
               tail_in        = NULL_LINK;
               resp_status_in = STAT_OK;
               resp_slot_in   = '0;
               state_in       = ST_RESP;
            end
         end
         ST_WALK: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_item_in.status   = STAT_OK;
               rsp_item_in.slot_out = SLOT_W'(cur_ff);
               rsp_item_in.last     = walk_last;
               k_in    = k_ff + WALK_CNT_W'(1);
               cur_in  = link_rd_ff;
               rd_addr = link_rd_ff[IW-1:0];
               if (walk_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_item_in.status   = resp_status_ff;
               rsp_item_in.slot_out = resp_slot_ff;
               rsp_item_in.last     = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         init_idx_ff  <= '0;
         free_head_ff <= '0;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_idx_ff  <= init_idx_in;
         free_head_ff <= free_head_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      rel_idx_ff     <= rel_idx_in;
      k_ff           <= k_in;
      resp_status_ff <= resp_status_in;
      resp_slot_ff   <= resp_slot_in;
      rsp_item_ff    <= rsp_item_in;
   end

   // an empty active list means the free list is not empty
   `OSP_ASSERT(a_free_when_empty, clock, reset, (head_ff >= NULL_LINK) |-> (free_head_ff < NULL_LINK))
   `OSP_ASSERT(a_head_tail_agree, clock, reset, (state_ff == ST_IDLE) |-> ((head_ff >= NULL_LINK) == (tail_ff >= NULL_LINK)))
   `OSP_ASSERT(a_empty_no_active, clock, reset, (state_ff == ST_IDLE) |-> ((head_ff >= NULL_LINK) == (active_ff == '0)))
   `OSP_ASSERT_NEVER(a_rel_walk_null, clock, reset, (state_ff == ST_REL_WALK) && (cur_ff >= NULL_LINK))

endmodule
